// ===== rtl/olie_pkg.sv =====
// ----------------------------------------------------------------------------
// Ordered list package
// Shared constants, operation codes and status codes for the ordered list.
// ----------------------------------------------------------------------------
package olie_pkg;

   localparam int DEPTH_DEF = 16;
   localparam int WORD_W    = 32;
   localparam int OP_W      = 2;
   localparam int STATUS_W  = 2;

   localparam logic [OP_W-1:0] OP_INSERT = 2'd0;
   localparam logic [OP_W-1:0] OP_ERASE  = 2'd1;
   localparam logic [OP_W-1:0] OP_READ   = 2'd2;

   localparam logic [STATUS_W-1:0] STATUS_OK      = 2'd0;
   localparam logic [STATUS_W-1:0] STATUS_FULL    = 2'd1;
   localparam logic [STATUS_W-1:0] STATUS_BAD_POS = 2'd2;

endpackage

// ===== rtl/olie_mem.sv =====
// ----------------------------------------------------------------------------
// Ordered list entry store
// Entry memory with separate write and read ports: one write and one registered read per cycle.
// ----------------------------------------------------------------------------
module olie_mem
   import olie_pkg::*;
#(
   parameter int DEPTH = DEPTH_DEF
) (
   input  logic                       clock,
   input  logic                       wr_en,
   input  logic [$clog2(DEPTH)-1:0]   wr_addr,
   input  logic signed [WORD_W-1:0]   wr_data,
   input  logic [$clog2(DEPTH)-1:0]   rd_addr,
   output logic signed [WORD_W-1:0]   rd_data
);

   logic signed [WORD_W-1:0] mem_ff [DEPTH];
   logic signed [WORD_W-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      rd_data_ff <= mem_ff[rd_addr];
   end

   assign rd_data = rd_data_ff;

endmodule

// ===== rtl/ordered_list_insert_erase.sv =====
// ----------------------------------------------------------------------------
// Ordered list with insert and erase
// Holds up to DEPTH signed words in order and inserts, erases or reads them
// by position, shifting later entries one at a time through the entry store.
// ----------------------------------------------------------------------------
// Usage: a transaction is accepted when start is high and busy is low. It
// carries req_op, req_position and req_value. Exactly one result follows,
// shown for one cycle with rsp_valid high; the receiver cannot stall it.
// A rejected transaction, and an erase of the last entry, is answered straight
// from the idle state; a read waits in ST_RD_WAIT for the registered memory
// read. An insert moves each entry from the position onward up one place,
// last entry first, and then writes the new value; an erase moves each later
// entry down one place. Every entry moved costs one memory read and one
// memory write in the entry store.
// busy stays high while a transaction is in progress and drops in the cycle
// its result is shown, so the next transaction may start then.
// Reset empties the list; stored words keep whatever they held, and only
// entries below the count are ever returned.
// ----------------------------------------------------------------------------
module ordered_list_insert_erase
   import olie_pkg::*;
#(
   parameter int DEPTH = DEPTH_DEF
) (
   input  logic                              clock,
   input  logic                              reset,
   input  logic                              start,
   output logic                              busy,
   input  logic [OP_W-1:0]                   req_op,
   input  logic [$clog2(DEPTH+1)-1:0]        req_position,
   input  logic signed [WORD_W-1:0]          req_value,
   output logic                              rsp_valid,
   output logic [STATUS_W-1:0]               rsp_status,
   output logic signed [WORD_W-1:0]          rsp_read_value,
   output logic [$clog2(DEPTH+1)-1:0]        rsp_count
);

   localparam int CNT_W = $clog2(DEPTH + 1);
   localparam int IDX_W = $clog2(DEPTH);

   typedef enum logic [2:0] {
      ST_IDLE,
      ST_INS_RD,
      ST_INS_WR,
      ST_INS_VAL,
      ST_ERS_RD,
      ST_ERS_WR,
      ST_RD_WAIT
   } state_type;

   state_type                   state_ff;
   logic [CNT_W-1:0]            count_ff;
   logic [CNT_W-1:0]            cursor_ff;
   logic [CNT_W-1:0]            pos_ff;
   logic signed [WORD_W-1:0]    value_ff;
   logic                        rsp_valid_ff;
   logic [STATUS_W-1:0]         rsp_status_ff;
   logic signed [WORD_W-1:0]    rsp_read_value_ff;
   logic [CNT_W-1:0]            rsp_count_ff;

   logic [CNT_W-1:0]            cursor_dec;
   logic [CNT_W-1:0]            cursor_inc;
   logic [CNT_W:0]              cursor_inc2;
   logic [CNT_W-1:0]            pos_inc;
   logic                        accept;

   logic                        mem_wr_en;
   logic [IDX_W-1:0]            mem_wr_addr;
   logic signed [WORD_W-1:0]    mem_wr_data;
   logic [IDX_W-1:0]            mem_rd_addr;
   logic signed [WORD_W-1:0]    mem_rd_data;

   assign accept      = start && !busy;
   assign cursor_dec  = cursor_ff - CNT_W'(1);
   assign cursor_inc  = cursor_ff + CNT_W'(1);
   assign cursor_inc2 = {1'b0, cursor_ff} + (CNT_W + 1)'(2);
   assign pos_inc     = req_position + CNT_W'(1);

   always_comb begin
      mem_wr_en   = 1'b0;
      mem_wr_addr = cursor_ff[IDX_W-1:0];
      mem_wr_data = mem_rd_data;
      mem_rd_addr = cursor_ff[IDX_W-1:0];
      case (state_ff)
         ST_IDLE: begin
            mem_rd_addr = req_position[IDX_W-1:0];
         end
         ST_INS_RD: begin
            mem_rd_addr = cursor_dec[IDX_W-1:0];
         end
         ST_ERS_RD: begin
            mem_rd_addr = cursor_inc[IDX_W-1:0];
         end
         ST_INS_WR, ST_ERS_WR: begin
            mem_wr_en = 1'b1;
         end
         ST_INS_VAL: begin
            mem_wr_en   = 1'b1;
            mem_wr_addr = pos_ff[IDX_W-1:0];
            mem_wr_data = value_ff;
         end
         default: begin
            mem_wr_en = 1'b0;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         count_ff     <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         rsp_valid_ff <= 1'b0;
         case (state_ff)
            ST_IDLE: begin
               if (accept) begin
                  pos_ff            <= req_position;
                  value_ff          <= req_value;
                  rsp_status_ff     <= STATUS_OK;
                  rsp_read_value_ff <= '0;
                  rsp_count_ff      <= count_ff;
                  case (req_op)
                     OP_INSERT: begin
                        if (req_position > count_ff) begin
                           rsp_status_ff <= STATUS_BAD_POS;
                           rsp_valid_ff  <= 1'b1;
                        end else if (count_ff == CNT_W'(DEPTH)) begin
                           rsp_status_ff <= STATUS_FULL;
                           rsp_valid_ff  <= 1'b1;
                        end else if (count_ff > req_position) begin
                           cursor_ff <= count_ff;
                           state_ff  <= ST_INS_RD;
                        end else begin
                           state_ff <= ST_INS_VAL;
                        end
                     end
                     OP_ERASE: begin
                        if (req_position >= count_ff) begin
                           rsp_status_ff <= STATUS_BAD_POS;
                           rsp_valid_ff  <= 1'b1;
                        end else if (pos_inc < count_ff) begin
                           cursor_ff <= req_position;
                           state_ff  <= ST_ERS_RD;
                        end else begin
                           count_ff     <= count_ff - CNT_W'(1);
                           rsp_count_ff <= count_ff - CNT_W'(1);
                           rsp_valid_ff <= 1'b1;
                        end
                     end
                     OP_READ: begin
                        if (req_position >= count_ff) begin
                           rsp_status_ff <= STATUS_BAD_POS;
                           rsp_valid_ff  <= 1'b1;
                        end else begin
                           state_ff <= ST_RD_WAIT;
                        end
                     end
                     default: begin
                        rsp_status_ff <= STATUS_BAD_POS;
                        rsp_valid_ff  <= 1'b1;
                     end
                  endcase
               end
            end
            ST_INS_RD: begin
               state_ff <= ST_INS_WR;
            end
            ST_INS_WR: begin
               cursor_ff <= cursor_dec;
               if (cursor_dec > pos_ff) begin
                  state_ff <= ST_INS_RD;
               end else begin
                  state_ff <= ST_INS_VAL;
               end
            end
            ST_INS_VAL: begin
               count_ff     <= count_ff + CNT_W'(1);
               rsp_count_ff <= count_ff + CNT_W'(1);
               rsp_valid_ff <= 1'b1;
               state_ff     <= ST_IDLE;
            end
            ST_ERS_RD: begin
               state_ff <= ST_ERS_WR;
            end
            ST_ERS_WR: begin
               cursor_ff <= cursor_inc;
               if (cursor_inc2 < {1'b0, count_ff}) begin
                  state_ff <= ST_ERS_RD;
               end else begin
                  count_ff     <= count_ff - CNT_W'(1);
                  rsp_count_ff <= count_ff - CNT_W'(1);
                  rsp_valid_ff <= 1'b1;
                  state_ff     <= ST_IDLE;
               end
            end
            ST_RD_WAIT: begin
               rsp_read_value_ff <= mem_rd_data;
               rsp_valid_ff      <= 1'b1;
               state_ff          <= ST_IDLE;
            end
            default: begin
               state_ff <= ST_IDLE;
            end
         endcase
      end
   end

   olie_mem #(
      .DEPTH (DEPTH)
   ) u_mem (
      .clock   (clock),
      .wr_en   (mem_wr_en),
      .wr_addr (mem_wr_addr),
      .wr_data (mem_wr_data),
      .rd_addr (mem_rd_addr),
      .rd_data (mem_rd_data)
   );

   assign busy           = (state_ff != ST_IDLE);
   assign rsp_valid      = rsp_valid_ff;
   assign rsp_status     = rsp_status_ff;
   assign rsp_read_value = rsp_read_value_ff;
   assign rsp_count      = rsp_count_ff;

   a_count_bound: assert property (@(posedge clock) disable iff (reset)
      count_ff <= CNT_W'(DEPTH))
      else $error("entry count exceeds capacity");

   a_accept_progress: assert property (@(posedge clock) disable iff (reset)
      accept |=> (busy || rsp_valid))
      else $error("accepted transaction neither in progress nor answered");

   a_full_count: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && rsp_status == STATUS_FULL) |-> (rsp_count == CNT_W'(DEPTH)))
      else $error("full status reported on a list that is not full");

   a_reject_zero: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && rsp_status != STATUS_OK) |-> (rsp_read_value == '0))
      else $error("rejected transaction returned a nonzero read value");

   a_no_write_idle: assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_IDLE) |-> !mem_wr_en)
      else $error("entry store written while idle");

endmodule

// ===== dv/tb_ordered_list_insert_erase.sv =====
// ----------------------------------------------------------------------------
// Ordered list insert/erase testbench
// Drives insert, erase and read transactions into the ordered list, predicts
// every result with a shadow copy of the list, and checks status, read value
// and count of each result in order. Covers the empty and full list, bad
// positions, the unused op code, and random traffic that repeatedly fills and
// empties the list, with phases of sender idling.
// ----------------------------------------------------------------------------
module tb_ordered_list_insert_erase;
   import olie_pkg::*;

   localparam int POS_W = $clog2(DEPTH_DEF + 1);
   localparam logic [OP_W-1:0] OP_UNUSED = 2'd3;
   localparam int MAX_GAP = 40;
   localparam int SETTLE_CYCLES = 2 * DEPTH_DEF + 8;
   localparam int RANDOM_CMDS = 1330;

   typedef struct {
      logic [OP_W-1:0]   op;
      logic [POS_W-1:0]  position;
      logic [WORD_W-1:0] value;
      int                gap;
      bit                drain;
   } list_cmd_type;

   typedef struct {
      logic [STATUS_W-1:0] status;
      logic [WORD_W-1:0]   read_value;
      logic [POS_W-1:0]    count;
   } list_result_type;

   logic                     clock = 1'b0;
   logic                     reset = 1'b1;
   logic                     start = 1'b0;
   logic                     busy;
   logic [OP_W-1:0]          req_op = '0;
   logic [POS_W-1:0]         req_position = '0;
   logic signed [WORD_W-1:0] req_value = '0;
   logic                     rsp_valid;
   logic [STATUS_W-1:0]      rsp_status;
   logic signed [WORD_W-1:0] rsp_read_value;
   logic [POS_W-1:0]         rsp_count;

   list_cmd_type    cmd_queue[$];
   list_result_type expected_results[$];
   list_cmd_type    cur_cmd;
   bit              cur_valid = 1'b0;
   int              hold_cycles = 0;
   logic            cmd_taken = 1'b0;

   logic [WORD_W-1:0] list_words[0:DEPTH_DEF-1];
   int                list_len = 0;

   int gen_len = 0;
   int idle_pct = 0;
   int errors = 0;
   int accepted = 0;
   int checked = 0;
   int full_hits = 0;
   int bad_pos_hits = 0;
   int full_reached = 0;

   ordered_list_insert_erase #(.DEPTH(DEPTH_DEF)) dut (
      .clock          (clock),
      .reset          (reset),
      .start          (start),
      .busy           (busy),
      .req_op         (req_op),
      .req_position   (req_position),
      .req_value      (req_value),
      .rsp_valid      (rsp_valid),
      .rsp_status     (rsp_status),
      .rsp_read_value (rsp_read_value),
      .rsp_count      (rsp_count)
   );

   initial begin
      forever #2 clock = ~clock;
   end

   function automatic list_result_type apply_list_op(input logic [OP_W-1:0] op,
                                                     input logic [POS_W-1:0] pos,
                                                     input logic [WORD_W-1:0] val);
      list_result_type r;
      int i;
      r.status = STATUS_OK;
      r.read_value = '0;
      if (op == OP_INSERT) begin
         if (pos > list_len) begin
            r.status = STATUS_BAD_POS;
         end else if (list_len >= DEPTH_DEF) begin
            r.status = STATUS_FULL;
         end else begin
            for (i = list_len; i > pos; i--) list_words[i] = list_words[i-1];
            list_words[pos] = val;
            list_len++;
         end
      end else if (op == OP_ERASE) begin
         if (pos >= list_len) begin
            r.status = STATUS_BAD_POS;
         end else begin
            for (i = pos; i + 1 < list_len; i++) list_words[i] = list_words[i+1];
            list_len--;
         end
      end else if (op == OP_READ) begin
         if (pos >= list_len) begin
            r.status = STATUS_BAD_POS;
         end else begin
            r.read_value = list_words[pos];
         end
      end else begin
         r.status = STATUS_BAD_POS;
      end
      r.count = list_len[POS_W-1:0];
      return r;
   endfunction

   function automatic logic [WORD_W-1:0] pick_word();
      logic [WORD_W-1:0] w;
      w = $urandom;
      if ($urandom_range(0, 7) == 0) begin
         case ($urandom_range(0, 4))
            0: w = 32'h8000_0000;
            1: w = 32'h7fff_ffff;
            2: w = 32'h0000_0000;
            3: w = 32'hffff_ffff;
            default: w = 32'h0000_0001;
         endcase
      end
      return w;
   endfunction

   // The generator tracks only the list length, so that positions can be
   // aimed at the valid range of the list as it will be when the command runs.
   task automatic queue_cmd(input logic [OP_W-1:0] op, input int pos,
                            input logic [WORD_W-1:0] val, input bit drain);
      list_cmd_type c;
      c.op = op;
      c.position = pos[POS_W-1:0];
      c.value = val;
      c.drain = drain;
      c.gap = ($urandom_range(0, 99) < idle_pct) ? $urandom_range(1, MAX_GAP) : 0;
      if (op == OP_INSERT && c.position <= gen_len && gen_len < DEPTH_DEF) gen_len++;
      else if (op == OP_ERASE && c.position < gen_len) gen_len--;
      cmd_queue.push_back(c);
   endtask

   always @(negedge clock) begin
      if (reset) begin
         start <= 1'b0;
      end else if (!(start && !cmd_taken)) begin
         if (start && cmd_taken) cur_valid = 1'b0;
         if (!cur_valid && cmd_queue.size() != 0) begin
            cur_cmd = cmd_queue.pop_front();
            cur_valid = 1'b1;
            hold_cycles = cur_cmd.gap;
         end
         if (cur_valid && hold_cycles == 0 &&
             !(cur_cmd.drain && expected_results.size() != 0)) begin
            start <= 1'b1;
            req_op <= cur_cmd.op;
            req_position <= cur_cmd.position;
            req_value <= cur_cmd.value;
         end else begin
            start <= 1'b0;
            req_op <= OP_W'($urandom);
            req_position <= POS_W'($urandom);
            req_value <= $urandom;
            if (hold_cycles > 0) hold_cycles--;
         end
      end
   end

   always @(posedge clock) begin
      list_result_type exp_r;
      if (reset) begin
         cmd_taken <= 1'b0;
      end else begin
         if (rsp_valid) begin
            if (expected_results.size() == 0) begin
               errors++;
               $display("%0t: unexpected result status=%0d read_value=%h count=%0d",
                        $time, rsp_status, rsp_read_value, rsp_count);
            end else begin
               exp_r = expected_results.pop_front();
               checked++;
               if (rsp_status !== exp_r.status) begin
                  errors++;
                  $display("%0t: status mismatch expected %0d actual %0d",
                           $time, exp_r.status, rsp_status);
               end
               if (rsp_read_value !== exp_r.read_value) begin
                  errors++;
                  $display("%0t: read_value mismatch expected %h actual %h",
                           $time, exp_r.read_value, rsp_read_value);
               end
               if (rsp_count !== exp_r.count) begin
                  errors++;
                  $display("%0t: count mismatch expected %0d actual %0d",
                           $time, exp_r.count, rsp_count);
               end
            end
         end
         cmd_taken <= start && !busy;
         if (start && !busy) begin
            exp_r = apply_list_op(req_op, req_position, req_value);
            expected_results.push_back(exp_r);
            accepted++;
            if (exp_r.status == STATUS_FULL) full_hits++;
            if (exp_r.status == STATUS_BAD_POS) bad_pos_hits++;
            if (exp_r.count == DEPTH_DEF) full_reached++;
         end
      end
   end

   initial begin
      bit filling;
      int k;
      int r;
      int pos;
      logic [OP_W-1:0] op;

      // Empty list: reads, erases and inserts beyond the end are rejected.
      queue_cmd(OP_READ, 0, 32'h1234_5678, 1'b0);
      queue_cmd(OP_ERASE, 0, 32'h0, 1'b0);
      queue_cmd(OP_INSERT, 1, 32'hdead_beef, 1'b0);
      queue_cmd(OP_UNUSED, 0, 32'h0, 1'b0);
      queue_cmd(OP_INSERT, 0, 32'h8000_0000, 1'b0);
      queue_cmd(OP_INSERT, 1, 32'h7fff_ffff, 1'b0);
      queue_cmd(OP_INSERT, 0, 32'hffff_ffff, 1'b0);
      queue_cmd(OP_INSERT, 1, 32'h0000_0000, 1'b0);
      while (gen_len < DEPTH_DEF) queue_cmd(OP_INSERT, $urandom_range(0, gen_len),
                                            pick_word(), 1'b0);
      // Full list: insert gives full, positions past the end stay rejected.
      queue_cmd(OP_INSERT, 5, 32'h5555_aaaa, 1'b0);
      queue_cmd(OP_INSERT, DEPTH_DEF + 1, 32'h0, 1'b0);
      queue_cmd(OP_INSERT, 31, 32'h0, 1'b0);
      queue_cmd(OP_READ, 0, 32'h0, 1'b0);
      queue_cmd(OP_READ, DEPTH_DEF - 1, 32'h0, 1'b0);
      queue_cmd(OP_READ, DEPTH_DEF, 32'h0, 1'b0);
      queue_cmd(OP_READ, 31, 32'h0, 1'b0);
      queue_cmd(OP_ERASE, DEPTH_DEF - 1, 32'h0, 1'b0);
      queue_cmd(OP_ERASE, 0, 32'h0, 1'b0);
      queue_cmd(OP_ERASE, 7, 32'h0, 1'b0);
      queue_cmd(OP_UNUSED, 31, 32'hffff_ffff, 1'b0);

      filling = 1'b0;
      for (k = 0; k < RANDOM_CMDS; k++) begin
         if (k < 300) idle_pct = 0;
         else if (k < 650) idle_pct = 54;
         else if (k < 1000) idle_pct = 0;
         else idle_pct = 26;
         if (gen_len == DEPTH_DEF) filling = 1'b0;
         else if (gen_len == 0) filling = 1'b1;
         else if ($urandom_range(0, 49) == 0) filling = !filling;
         r = $urandom_range(0, 99);
         if (r < 3) op = OP_UNUSED;
         else if (filling) op = (r < 58) ? OP_INSERT : (r < 78) ? OP_ERASE : OP_READ;
         else op = (r < 23) ? OP_INSERT : (r < 78) ? OP_ERASE : OP_READ;
         if ($urandom_range(0, 99) < 12) pos = $urandom_range(0, 31);
         else if (op == OP_INSERT) pos = $urandom_range(0, gen_len);
         else pos = (gen_len == 0) ? 0 : $urandom_range(0, gen_len - 1);
         queue_cmd(op, pos, pick_word(), (k % 150) == 0);
      end

      repeat (6) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;

      while (cmd_queue.size() != 0 || cur_valid || expected_results.size() != 0)
         @(posedge clock);
      repeat (SETTLE_CYCLES) @(posedge clock);

      $display("Checked %0d of %0d transactions: %0d full rejects, %0d bad positions,",
               checked, accepted, full_hits, bad_pos_hits);
      $display("and %0d results with the list at full capacity.", full_reached);
      if (errors == 0 && expected_results.size() == 0) begin
         $display("[ OK ] regression clean");
      end else begin
         $display("[FAIL] regression broken");
      end
      $finish;
   end

   initial begin
      #4000000;
      $display("%0t: timeout with %0d results outstanding", $time,
               expected_results.size());
      $display("[FAIL] regression broken");
      $finish;
   end

endmodule

// ===== ordered_list_insert_erase.f =====
rtl/olie_pkg.sv
rtl/olie_mem.sv
rtl/ordered_list_insert_erase.sv
dv/tb_ordered_list_insert_erase.sv
